// ===== rtl/core/uapq_pkg.sv =====
// Shared types and codes for the unsorted array priority queue.
package uapq_pkg;

   localparam int KEY_IN_BITS = 32;
   localparam int PRIO_BITS   = 32;
   localparam int OCC_BITS    = 7;

   typedef enum logic [2:0] {
      ACT_ENQUEUE = 3'd0,
      ACT_DEQUEUE = 3'd1,
      ACT_PEEK    = 3'd2,
      ACT_CHANGE  = 3'd3,
      ACT_CLEAR   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK              = 3'd0,
      ST_EMPTY           = 3'd1,
      ST_NOT_FOUND       = 3'd2,
      ST_NOT_MORE_URGENT = 3'd3,
      ST_FULL            = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_SHIFT,
      FSM_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]                  action;
      logic [KEY_IN_BITS-1:0]      item_key;
      logic signed [PRIO_BITS-1:0] item_priority;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]                  status;
      logic [KEY_IN_BITS-1:0]      result_key;
      logic signed [PRIO_BITS-1:0] result_priority;
      logic [OCC_BITS-1:0]         occupancy;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic sweep;
      logic shift;
      logic shift_init;
      logic commit;
   } uapq_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       sweep_done;
      logic       best_vld;
      logic       out_free;
   } uapq_status_type;

endpackage

// ===== rtl/core/uapq_ctrl.sv =====
// Controller state machine: sequences scan, compaction and response for each action.
module uapq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [2:0]               req_action,
   output logic                     req_stall,
   input  uapq_pkg::uapq_status_type stat,
   output uapq_pkg::uapq_cmd_type    cmd
);
   import uapq_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               if (req_action inside {ACT_DEQUEUE, ACT_PEEK, ACT_CHANGE}) begin
                  state_in = FSM_SCAN;
               end else begin
                  state_in = FSM_FINISH;
               end
            end
         end
         FSM_SCAN: begin
            if (stat.sweep_done) begin
               if (stat.action == ACT_DEQUEUE && stat.best_vld) begin
                  state_in = FSM_SHIFT;
               end else begin
                  state_in = FSM_FINISH;
               end
            end
         end
         FSM_SHIFT: begin
            if (stat.sweep_done) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (stat.out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         FSM_SCAN: begin
            cmd.sweep      = 1'b1;
            cmd.shift_init = stat.sweep_done && stat.action == ACT_DEQUEUE && stat.best_vld;
         end
         FSM_SHIFT: begin
            cmd.sweep = 1'b1;
            cmd.shift = 1'b1;
         end
         FSM_FINISH: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/uapq_datapath.sv =====
// Datapath: entry memories, scan and compaction engine, count and response register.
module uapq_datapath #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  uapq_pkg::req_payload_type req_data,
   input  uapq_pkg::uapq_cmd_type    cmd,
   output uapq_pkg::uapq_status_type stat,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output uapq_pkg::rsp_payload_type rsp_data
);
   import uapq_pkg::*;

   localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [KW-1:0]                key_mem [DEPTH];
   logic signed [PRIO_BITS-1:0]  prio_mem [DEPTH];

   logic [2:0]                   act_ff;
   logic [KW-1:0]                key_ff;
   logic signed [PRIO_BITS-1:0]  prio_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic                         pend_ff, pend_in;
   logic [AW-1:0]                pend_idx_ff;
   logic [KW-1:0]                rd_key_ff;
   logic signed [PRIO_BITS-1:0]  rd_prio_ff;
   logic                         best_vld_ff, best_vld_in;
   logic [AW-1:0]                best_idx_ff;
   logic [KW-1:0]                best_key_ff;
   logic signed [PRIO_BITS-1:0]  best_prio_ff;
   logic                         found_ff, found_in;
   logic [AW-1:0]                match_idx_ff;
   logic signed [PRIO_BITS-1:0]  match_prio_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_data_ff;

   logic                         issue;
   logic                         take_best;
   logic                         take_match;
   logic                         wr_key_en;
   logic                         wr_prio_en;
   logic [AW-1:0]                wr_addr;
   logic [KW-1:0]                wr_key;
   logic signed [PRIO_BITS-1:0]  wr_prio;
   status_type                   status_in;

   assign issue = cmd.sweep && (rd_ptr_ff < count_ff);

   // strict compare keeps the earliest of equal entries
   assign take_best = cmd.sweep && !cmd.shift && pend_ff &&
                      (!best_vld_ff || rd_prio_ff < best_prio_ff ||
                       (rd_prio_ff == best_prio_ff && rd_key_ff < best_key_ff));
   assign take_match = cmd.sweep && !cmd.shift && pend_ff && !found_ff &&
                       rd_key_ff == key_ff;

   assign stat.action     = act_ff;
   assign stat.sweep_done = !pend_ff && (rd_ptr_ff >= count_ff);
   assign stat.best_vld   = best_vld_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // single write port shared by compaction, append and priority update
   always_comb begin
      wr_key_en  = 1'b0;
      wr_prio_en = 1'b0;
      wr_addr    = pend_idx_ff - 1'b1;
      wr_key     = rd_key_ff;
      wr_prio    = rd_prio_ff;
      if (cmd.sweep && cmd.shift && pend_ff) begin
         wr_key_en  = 1'b1;
         wr_prio_en = 1'b1;
      end else if (cmd.commit) begin
         case (act_ff)
            ACT_ENQUEUE: begin
               wr_key_en  = count_ff < DEPTH_C;
               wr_prio_en = count_ff < DEPTH_C;
               wr_addr    = count_ff[AW-1:0];
               wr_key     = key_ff;
               wr_prio    = prio_ff;
            end
            ACT_CHANGE: begin
               wr_prio_en = found_ff && (match_prio_ff > prio_ff);
               wr_addr    = match_idx_ff;
               wr_prio    = prio_ff;
            end
            default: begin
               wr_key_en  = 1'b0;
               wr_prio_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      if (cmd.commit) begin
         case (act_ff)
            ACT_ENQUEUE: begin
               if (count_ff < DEPTH_C) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
            ACT_DEQUEUE: begin
               if (best_vld_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            ACT_PEEK: begin
               if (!best_vld_ff) begin
                  status_in = ST_EMPTY;
               end
            end
            ACT_CHANGE: begin
               if (!found_ff) begin
                  status_in = ST_NOT_FOUND;
               end else if (match_prio_ff <= prio_ff) begin
                  status_in = ST_NOT_MORE_URGENT;
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      pend_in     = 1'b0;
      best_vld_in = best_vld_ff;
      found_in    = found_ff;
      if (cmd.load) begin
         rd_ptr_in   = '0;
         best_vld_in = 1'b0;
         found_in    = 1'b0;
      end else if (cmd.shift_init) begin
         rd_ptr_in = CW'(best_idx_ff) + CW'(1);
      end else if (issue) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         pend_in   = 1'b1;
      end
      if (take_best) begin
         best_vld_in = 1'b1;
      end
      if (take_match) begin
         found_in = 1'b1;
      end
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         best_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         best_vld_ff  <= best_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_data.action;
         key_ff  <= req_data.item_key[KW-1:0];
         prio_ff <= req_data.item_priority;
      end
      if (issue) begin
         pend_idx_ff <= rd_ptr_ff[AW-1:0];
      end
      if (take_best) begin
         best_idx_ff  <= pend_idx_ff;
         best_key_ff  <= rd_key_ff;
         best_prio_ff <= rd_prio_ff;
      end
      if (take_match) begin
         match_idx_ff  <= pend_idx_ff;
         match_prio_ff <= rd_prio_ff;
      end
      if (cmd.commit) begin
         rsp_data_ff.status    <= status_in;
         rsp_data_ff.occupancy <= OCC_BITS'(count_in);
         if ((act_ff == ACT_DEQUEUE || act_ff == ACT_PEEK) && best_vld_ff) begin
            rsp_data_ff.result_key      <= KEY_IN_BITS'(best_key_ff);
            rsp_data_ff.result_priority <= best_prio_ff;
         end else begin
            rsp_data_ff.result_key      <= '0;
            rsp_data_ff.result_priority <= '0;
         end
      end
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_prio_en) begin
         prio_mem[wr_addr] <= wr_prio;
      end
      if (issue) begin
         rd_key_ff  <= key_mem[rd_ptr_ff[AW-1:0]];
         rd_prio_ff <= prio_mem[rd_ptr_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/unsorted_array_priority_queue.sv =====
// Top level of the unsorted array priority queue (N = entries held when the item starts).
// Enqueue, clear and undefined codes go straight to the result; peek and change priority
// scan all N entries; dequeue scans all N, then shifts down each entry after the one removed
// (none when the newest entry is removed or the queue is empty).
// One item at a time through the single-port scan of the entry memory; a new transfer is
// taken once the result is loaded, while that result may still wait on rsp_stall.
// Reset empties the queue and clears control state; entry memory contents are kept.
module unsorted_array_priority_queue #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  uapq_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output uapq_pkg::rsp_payload_type rsp_data
);
   import uapq_pkg::*;

   uapq_cmd_type    cmd;
   uapq_status_type stat;

   uapq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   uapq_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/uapq_checker.sv =====
// Port-level checker for the unsorted array priority queue and its bind.
module uapq_checker #(
   parameter int DEPTH = 64
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input uapq_pkg::rsp_payload_type rsp_data
);
   import uapq_pkg::*;

   // an accepted transfer leaves the block busy, with req_stall raised
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken right after an accepted transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.occupancy == OCC_BITS'(DEPTH))
      else $error("full status without a full queue");

   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.occupancy == '0)
      else $error("empty status with entries held");

   a_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.result_key == '0 && rsp_data.result_priority == '0)
      else $error("result fields set on a failed action");

endmodule

bind unsorted_array_priority_queue uapq_checker #(.DEPTH(DEPTH)) u_uapq_checker (.*);

// ===== tb/sv/unsorted_array_priority_queue_tb.sv =====
// Self-checking testbench for the unsorted array priority queue, with random handshakes.
module unsorted_array_priority_queue_tb;
   import uapq_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int RANDOM_OPS  = 1000;
   localparam int DRAIN_WAIT  = 2 * QUEUE_DEPTH + 8;

   localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] ACT_MID_UNUSED   = 3'd6;
   localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

   localparam logic [KEY_IN_BITS-1:0] KEY_MASK = (KEY_WIDTH >= KEY_IN_BITS) ?
      {KEY_IN_BITS{1'b1}} : ({KEY_IN_BITS{1'b1}} >> (KEY_IN_BITS - KEY_WIDTH));
   localparam logic signed [PRIO_BITS-1:0] PRIO_MIN = {1'b1, {(PRIO_BITS-1){1'b0}}};
   localparam logic signed [PRIO_BITS-1:0] PRIO_MAX = {1'b0, {(PRIO_BITS-1){1'b1}}};

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   unsorted_array_priority_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .KEY_BITS (KEY_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Predicted contents of the queue, in arrival order
   logic [KEY_IN_BITS-1:0]      held_keys  [QUEUE_DEPTH];
   logic signed [PRIO_BITS-1:0] held_prios [QUEUE_DEPTH];
   int                          held_count = 0;

   req_payload_type        pending_ops [$];
   rsp_payload_type        owed_replies [$];
   logic [KEY_IN_BITS-1:0] recent_keys [$];
   int                     planned_count = 0;
   int                     mismatch_count = 0;

   int   req_gap = 0;
   bit   req_calm = 1'b0;
   logic req_holding;
   int   rsp_wait = 0;
   bit   rsp_calm = 1'b0;
   rsp_payload_type want_rsp;

   function automatic rsp_payload_type apply_queue_op(req_payload_type op);
      rsp_payload_type             reply;
      logic [KEY_IN_BITS-1:0]      key;
      logic signed [PRIO_BITS-1:0] prio;
      int                          best;
      bit                          matched;
      reply   = '0;
      key     = op.item_key & KEY_MASK;
      prio    = op.item_priority;
      best    = 0;
      matched = 1'b0;
      reply.status = ST_OK;
      case (op.action)
         ACT_ENQUEUE: begin
            if (held_count >= QUEUE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               held_keys[held_count]  = key;
               held_prios[held_count] = prio;
               held_count++;
            end
         end
         ACT_DEQUEUE, ACT_PEEK: begin
            if (held_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               // lowest number wins, then smaller key, then earliest slot
               for (int i = 1; i < held_count; i++) begin
                  if (held_prios[i] < held_prios[best] ||
                      (held_prios[i] == held_prios[best] && held_keys[i] < held_keys[best]))
                     best = i;
               end
               reply.result_key      = held_keys[best];
               reply.result_priority = held_prios[best];
               if (op.action == ACT_DEQUEUE) begin
                  for (int i = best; i + 1 < held_count; i++) begin
                     held_keys[i]  = held_keys[i + 1];
                     held_prios[i] = held_prios[i + 1];
                  end
                  held_count--;
               end
            end
         end
         ACT_CHANGE: begin
            reply.status = ST_NOT_FOUND;
            for (int i = 0; i < held_count; i++) begin
               if (!matched && held_keys[i] == key) begin
                  matched = 1'b1;
                  if (held_prios[i] <= prio) begin
                     reply.status = ST_NOT_MORE_URGENT;
                  end else begin
                     held_prios[i] = prio;
                     reply.status  = ST_OK;
                  end
               end
            end
         end
         ACT_CLEAR: held_count = 0;
         default: ;
      endcase
      reply.occupancy = held_count[OCC_BITS-1:0];
      return reply;
   endfunction

   task automatic plan_op(input logic [2:0] action, input logic [KEY_IN_BITS-1:0] key,
                          input logic signed [PRIO_BITS-1:0] prio);
      req_payload_type op;
      op.action        = action;
      op.item_key      = key;
      op.item_priority = prio;
      pending_ops.push_back(op);
      case (action)
         ACT_ENQUEUE: begin
            if (planned_count < QUEUE_DEPTH) planned_count++;
            recent_keys.push_back(key);
            if (recent_keys.size() > 32) void'(recent_keys.pop_front());
         end
         ACT_DEQUEUE: if (planned_count > 0) planned_count--;
         ACT_CLEAR:   planned_count = 0;
         default: ;
      endcase
   endtask

   function automatic logic [KEY_IN_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return KEY_IN_BITS'($urandom_range(0, 15));
         1: return $urandom();
         2: return $urandom_range(0, 1) ? '1 : '0;
         default: begin
            if (recent_keys.size() == 0) return $urandom();
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         end
      endcase
   endfunction

   function automatic logic signed [PRIO_BITS-1:0] pick_prio();
      case ($urandom_range(0, 3))
         0: return $signed(PRIO_BITS'($urandom_range(0, 8))) - 4;
         1: return $signed($urandom());
         2: return $urandom_range(0, 1) ? PRIO_MIN : PRIO_MAX;
         default: return $signed(PRIO_BITS'($urandom_range(0, 2000))) - 1000;
      endcase
   endfunction

   // Request driver: one transfer per item, random gap after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_gap     = 0;
         held_count  = 0;
      end else begin
         req_holding = req_valid;
         if (req_valid && !req_stall) begin
            owed_replies.push_back(apply_queue_op(req_data));
            req_holding = 1'b0;
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 17);
         end
         if (!req_holding) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req_data  <= pending_ops.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result stall: a random wait, drawn at each taken result, counts down only while a result is valid
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         rsp_wait = rsp_calm ? 0 : $urandom_range(0, 17);
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_stall <= (rsp_wait > 0);
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
      mismatch_count++;
   endtask

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_replies.size() == 0) begin
            report_mismatch("result with nothing pending", '0, {29'b0, rsp_data.status});
         end else begin
            want_rsp = owed_replies.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", {29'b0, want_rsp.status}, {29'b0, rsp_data.status});
            if (rsp_data.result_key !== want_rsp.result_key)
               report_mismatch("result_key", want_rsp.result_key, rsp_data.result_key);
            if (rsp_data.result_priority !== want_rsp.result_priority)
               report_mismatch("result_priority", want_rsp.result_priority,
                               rsp_data.result_priority);
            if (rsp_data.occupancy !== want_rsp.occupancy)
               report_mismatch("occupancy", {25'b0, want_rsp.occupancy},
                               {25'b0, rsp_data.occupancy});
         end
      end
   end

   initial begin
      int random_ops;
      int kind;
      int n;
      random_ops = 0;

      // Directed: empty queue, extreme fields, ties, change outcomes, unused codes
      plan_op(ACT_DEQUEUE, '0, '0);
      plan_op(ACT_PEEK, '0, '0);
      plan_op(ACT_CHANGE, '0, '0);
      plan_op(ACT_ENQUEUE, '0, PRIO_MAX);
      plan_op(ACT_ENQUEUE, '1, PRIO_MIN);
      plan_op(ACT_ENQUEUE, 32'd5, PRIO_MIN);
      plan_op(ACT_ENQUEUE, 32'd5, PRIO_MIN);
      plan_op(ACT_PEEK, '1, PRIO_MAX);
      plan_op(ACT_CHANGE, '0, PRIO_MAX);
      plan_op(ACT_CHANGE, '0, 32'sd0);
      plan_op(ACT_CHANGE, '0, 32'sd1);
      plan_op(ACT_CHANGE, 32'd123, PRIO_MIN);
      plan_op(ACT_FIRST_UNUSED, '1, PRIO_MIN);
      plan_op(ACT_MID_UNUSED, 32'hA5A5_5A5A, 32'sh5A5A_A5A5);
      plan_op(ACT_LAST_UNUSED, '0, PRIO_MAX);
      plan_op(ACT_DEQUEUE, '1, PRIO_MAX);
      plan_op(ACT_DEQUEUE, '0, '0);
      plan_op(ACT_CLEAR, '1, PRIO_MIN);
      plan_op(ACT_DEQUEUE, '0, '0);
      plan_op(ACT_ENQUEUE, 32'h8000_0001, -32'sd1);
      plan_op(ACT_CLEAR, '0, '0);

      while (random_ops < RANDOM_OPS) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               // fill, past full on the first kind
               n = (kind == 0) ? QUEUE_DEPTH - planned_count + $urandom_range(1, 3)
                               : $urandom_range(1, 24);
               for (int i = 0; i < n; i++) begin
                  plan_op(ACT_ENQUEUE, pick_key(), pick_prio());
                  if ($urandom_range(0, 4) == 0) plan_op(ACT_PEEK, pick_key(), pick_prio());
               end
               random_ops += n;
            end
            3, 4: begin
               n = planned_count + $urandom_range(0, 2);
               for (int i = 0; i < n; i++) plan_op(ACT_DEQUEUE, pick_key(), pick_prio());
               random_ops += n;
            end
            8: begin
               for (int i = 0; i < 10; i++) plan_op(ACT_CHANGE, pick_key(), pick_prio());
               random_ops += 10;
            end
            9: begin
               plan_op(ACT_CLEAR, pick_key(), pick_prio());
               random_ops++;
            end
            default: begin
               for (int i = 0; i < 20; i++) begin
                  n = $urandom_range(0, 99);
                  if (n < 30)      plan_op(ACT_ENQUEUE, pick_key(), pick_prio());
                  else if (n < 55) plan_op(ACT_DEQUEUE, pick_key(), pick_prio());
                  else if (n < 70) plan_op(ACT_PEEK, pick_key(), pick_prio());
                  else if (n < 95) plan_op(ACT_CHANGE, pick_key(), pick_prio());
                  else if (n < 97) plan_op(ACT_CLEAR, pick_key(), pick_prio());
                  else plan_op(3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)),
                               pick_key(), pick_prio());
               end
               random_ops += 20;
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver's updates have settled
      while (pending_ops.size() > 0 || req_valid) @(negedge clock);
      while (owed_replies.size() > 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && owed_replies.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
